### src/theta_scheme_sor_grid_solver_core_assert.svh
// Assertion macros for the theta-scheme SOR grid solver core.
// Used by the top level only; no other dependencies.
`ifndef THETA_SCHEME_SOR_GRID_SOLVER_CORE_ASSERT_SVH
`define THETA_SCHEME_SOR_GRID_SOLVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TSOR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsor assertion failed");
// next-cycle implication
`define TSOR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsor assertion failed");
`else
`define TSOR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSOR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/tsor_pkg.sv
// Shared constants, types and saturating Q24.40 arithmetic for the SOR solver.
// No dependencies.
package tsor_pkg;

  localparam int MAX_SPACE_STEPS = 1024;
  localparam int MAX_SWEEPS      = 1000;
  localparam int NODE_SLOTS      = MAX_SPACE_STEPS + 1;
  localparam int ADDR_W          = $clog2(NODE_SLOTS);
  localparam int CNT_W           = $clog2(NODE_SLOTS + 2);
  localparam int SWP_W           = $clog2(MAX_SWEEPS + 1);
  localparam int FRAC_BITS       = 40;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_BAD = 2'd1;
  localparam logic [1:0] STATUS_CAP = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    CFG_LHS_LEFT   = 3'd0,
    CFG_LHS_RIGHT  = 3'd1,
    CFG_RHS_LEFT   = 3'd2,
    CFG_RHS_CENTER = 3'd3,
    CFG_RHS_RIGHT  = 3'd4,
    CFG_RELAXATION = 3'd5,
    CFG_TOLERANCE  = 3'd6,
    CFG_TIME_STEPS = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LEFT_Q,
    OP_MID_Q,
    OP_RIGHT_RHS,
    OP_RIGHT_ZERO,
    OP_MUL,
    OP_ACC_ADD,
    OP_ACC_SUB,
    OP_SUB_MID,
    OP_NEW,
    OP_TERM,
    OP_SUM,
    OP_SHIFT,
    OP_CLR_SUMS,
    OP_BOUND,
    OP_RESULT
  } dp_op_t;

  typedef enum logic [2:0] {
    M_LL, M_LR, M_RL, M_RC, M_RR, M_OM, M_BOUND
  } mul_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_W0, ST_W1, ST_W2, ST_RD, ST_LD, ST_MSTART, ST_MWAIT,
    ST_RHS_WR, ST_PRE_OM, ST_TERM, ST_SUM, ST_CHECK, ST_SWP_START,
    ST_RES0, ST_RES1, ST_RES2, ST_RES3, ST_RES4, ST_BAD
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t     op;
    mul_sel_t   msel;
    addr_t      g_raddr;
    logic       g_we;
    addr_t      g_waddr;
    logic       g_wsel;   // 1: new node value, 0: input word
    addr_t      r_raddr;
    logic       r_we;
    addr_t      r_waddr;
    addr_t      weight;
    logic [1:0] status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic        mul_done;
    logic        converged;
    logic [15:0] time_steps;
  } dp_stat_t;

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

  function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63])
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

  function automatic logic [63:0] add_usat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [63:0] mag_of(input logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] dist_of(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic [64:0] d;
    d = {a[63], a} - {b[63], b};
    return d[64] ? 64'(~d + 65'd1) : d[63:0];
  endfunction

  // scale a raw magnitude product by 2^-40 with rounding, sign and saturation
  function automatic logic signed [63:0] q_finish(input logic [127:0] p, input logic neg);
    logic [64:0] r;
    logic        over;
    logic signed [63:0] res;
    over = |p[127:FRAC_BITS+64];
    r    = {1'b0, p[FRAC_BITS+63:FRAC_BITS]} + {64'd0, p[FRAC_BITS-1]};
    over = over | r[64] | r[63];
    if (neg)
      res = (over && !(r[63] && ~|r[62:0] && !r[64] && ~|p[127:FRAC_BITS+64]))
            ? {1'b1, 63'd0} : 64'(~r[63:0] + 64'd1);
    else
      res = over ? {1'b0, {63{1'b1}}} : r[63:0];
    return res;
  endfunction

endpackage

### src/theta_scheme_sor_grid_solver_core.sv
// Theta-scheme SOR grid solver, top level.
// Channels: in_ (node_value, last_node) and out_ (price, neighbour_difference,
// status), both valid/stall; cfg_ is a plain write port, eight registers.
// Load: one node word accepted per cycle while idle, node i to grid slot i.
// The word with last_node set starts the solve (or a bad-count result); in_stall
// stays high until the result word has been placed in the output register.
// Solve time is set by the shared 64x64 multiplier: each time step runs a
// right-hand-side pass over the interior nodes, then sweeps until converged or
// capped; the solve repeats that time_steps times.
// A bad node count returns its result once the output register is empty.
// The output register holds the word while out_stall is high; loading of the
// next grid goes on meanwhile. A finished solve waits for it to empty.
// Reset (synchronous, rst_n low) returns control and config registers to defaults;
// grid contents are undefined until loaded. No clearing pass is needed.
// Depends on tsor_pkg, tsor_ctrl, tsor_datapath, tsor_mul.
`include "theta_scheme_sor_grid_solver_core_assert.svh"
module theta_scheme_sor_grid_solver_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [63:0] in_node_value,
  input  logic               in_last_node,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_price,
  output logic signed [63:0] out_neighbour_difference,
  output logic [1:0]         out_status
);
  import tsor_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tsor_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_node (in_last_node),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  tsor_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .node_value           (in_node_value),
    .cmd                  (cmd),
    .stat                 (stat),
    .price                (out_price),
    .neighbour_difference (out_neighbour_difference),
    .status               (out_status)
  );

  // a final node word always starts a solve or a bad-count result
  `TSOR_ASSERT_NXT(a_last_blocks, clk, rst_n, in_valid && !in_stall && in_last_node, in_stall)
  `TSOR_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_status != 2'd3)
  `TSOR_ASSERT_IMP(a_bad_zero, clk, rst_n, out_valid && out_status == STATUS_BAD,
    out_price == 64'sd0 && out_neighbour_difference == 64'sd0)

endmodule

### src/tsor_mul.sv
// Shared 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// Depends on nothing; result valid when done pulses.
module tsor_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         done
);

  logic [63:0]  a_r, b_r;
  logic [127:0] prod_r;
  logic         busy_r, done_r;
  logic [1:0]   idx_r;
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [6:0]   shamt;

  // pick partial product for this cycle
  assign a_half = idx_r[0] ? a_r[63:32] : a_r[31:0];
  assign b_half = idx_r[1] ? b_r[63:32] : b_r[31:0];
  assign pp     = a_half * b_half;
  assign shamt  = (7'(idx_r[0]) + 7'(idx_r[1])) << 5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= 2'd0;
      end else if (busy_r) begin
        idx_r <= idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      b_r    <= b;
      prod_r <= '0;
    end else if (busy_r) begin
      prod_r <= prod_r + ({64'd0, pp} << shamt);
    end
  end

  assign prod = prod_r;
  assign done = done_r;

endmodule

### src/tsor_datapath.sv
// Datapath: config registers, grid and rhs memories, node window, accumulators.
// Depends on tsor_pkg and tsor_mul.
module tsor_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic signed [63:0]  node_value,
  input  tsor_pkg::dp_cmd_t   cmd,
  output tsor_pkg::dp_stat_t  stat,
  output logic signed [63:0]  price,
  output logic signed [63:0]  neighbour_difference,
  output logic [1:0]          status
);
  import tsor_pkg::*;

  logic signed [63:0] lhs_left_r, lhs_right_r, rhs_left_r, rhs_center_r, rhs_right_r;
  logic [41:0]        relax_r;
  logic [40:0]        tol_r;
  logic [15:0]        steps_r;

  logic signed [63:0] grid_mem [NODE_SLOTS];
  logic signed [63:0] rhs_mem [NODE_SLOTS];
  logic signed [63:0] grid_q, rhs_q;

  logic signed [63:0] left_r, mid_r, right_r, acc_r, nv_r;
  logic [63:0]        change_r, magsum_r, term_r, magterm_r, bound_r;
  logic               neg_r;
  logic signed [63:0] price_r, diff_r;
  logic [1:0]         status_r;

  logic signed [63:0] op_a, op_b;
  logic [63:0]        mul_a, mul_b, norm;
  logic               mul_neg;
  logic [127:0]       prod;
  logic               mul_done;
  logic signed [63:0] prod_q;
  logic [74:0]        wterm;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lhs_left_r   <= '0;
      lhs_right_r  <= '0;
      rhs_left_r   <= '0;
      rhs_center_r <= '0;
      rhs_right_r  <= '0;
      relax_r      <= 42'd1649267441664;
      tol_r        <= 41'd1099512;
      steps_r      <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LHS_LEFT:   lhs_left_r   <= cfg_data;
        CFG_LHS_RIGHT:  lhs_right_r  <= cfg_data;
        CFG_RHS_LEFT:   rhs_left_r   <= cfg_data;
        CFG_RHS_CENTER: rhs_center_r <= cfg_data;
        CFG_RHS_RIGHT:  rhs_right_r  <= cfg_data;
        CFG_RELAXATION: relax_r      <= cfg_data[41:0];
        CFG_TOLERANCE:  tol_r        <= cfg_data[40:0];
        CFG_TIME_STEPS: steps_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // grid and rhs memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.g_we)
      grid_mem[cmd.g_waddr] <= cmd.g_wsel ? nv_r : node_value;
    grid_q <= grid_mem[cmd.g_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.r_we)
      rhs_mem[cmd.r_waddr] <= acc_r;
    rhs_q <= rhs_mem[cmd.r_raddr];
  end

  // multiplier operand select
  assign norm = (magsum_r < (64'd1 << FRAC_BITS)) ? (64'd1 << FRAC_BITS) : magsum_r;

  always_comb begin
    op_a = lhs_left_r;
    op_b = left_r;
    case (cmd.msel)
      M_LL:    begin op_a = lhs_left_r;   op_b = left_r;  end
      M_LR:    begin op_a = lhs_right_r;  op_b = right_r; end
      M_RL:    begin op_a = rhs_left_r;   op_b = left_r;  end
      M_RC:    begin op_a = rhs_center_r; op_b = mid_r;   end
      M_RR:    begin op_a = rhs_right_r;  op_b = right_r; end
      M_OM:    begin op_a = {22'd0, relax_r}; op_b = acc_r; end
      default: ;
    endcase
    if (cmd.msel == M_BOUND) begin
      mul_a   = {23'd0, tol_r};
      mul_b   = norm;
      mul_neg = 1'b0;
    end else begin
      mul_a   = mag_of(op_a);
      mul_b   = mag_of(op_b);
      mul_neg = op_a[63] ^ op_b[63];
    end
  end

  tsor_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_MUL),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .done  (mul_done)
  );

  assign prod_q = q_finish(prod, neg_r);
  assign wterm  = dist_of(nv_r, mid_r) * cmd.weight;

  // datapath operations
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LEFT_Q:     left_r <= grid_q;
      OP_MID_Q:      mid_r <= grid_q;
      OP_RIGHT_RHS:  begin right_r <= grid_q; acc_r <= rhs_q; end
      OP_RIGHT_ZERO: begin right_r <= grid_q; acc_r <= '0; end
      OP_MUL:        neg_r <= mul_neg;
      OP_ACC_ADD:    acc_r <= add_sat(acc_r, prod_q);
      OP_ACC_SUB:    acc_r <= sub_sat(acc_r, prod_q);
      OP_SUB_MID:    acc_r <= sub_sat(acc_r, mid_r);
      OP_NEW:        nv_r <= add_sat(mid_r, prod_q);
      OP_TERM: begin
        term_r    <= (|wterm[74:64]) ? {64{1'b1}} : wterm[63:0];
        magterm_r <= mag_of(nv_r);
      end
      OP_SUM: begin
        change_r <= add_usat(change_r, term_r);
        magsum_r <= add_usat(magsum_r, magterm_r);
        left_r   <= nv_r;
        mid_r    <= right_r;
      end
      OP_SHIFT: begin
        left_r <= mid_r;
        mid_r  <= right_r;
      end
      OP_CLR_SUMS: begin
        change_r <= '0;
        magsum_r <= '0;
      end
      OP_BOUND:
        bound_r <= (|prod[127:FRAC_BITS+64]) ? {64{1'b1}} : prod[FRAC_BITS+63:FRAC_BITS];
      default: ;
    endcase
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RESULT) begin
      status_r <= cmd.status;
      if (cmd.status == STATUS_BAD) begin
        price_r <= '0;
        diff_r  <= '0;
      end else begin
        price_r <= mid_r;
        diff_r  <= sub_sat(right_r, left_r);
      end
    end
  end

  assign stat.mul_done   = mul_done;
  assign stat.converged  = (change_r <= bound_r);
  assign stat.time_steps = steps_r;

  assign price                = price_r;
  assign neighbour_difference = diff_r;
  assign status               = status_r;

endmodule

### src/tsor_ctrl.sv
// Controller: load counting, time-step / sweep / node sequencing, result handshake.
// Depends on tsor_pkg.
module tsor_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last_node,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  tsor_pkg::dp_stat_t stat,
  output tsor_pkg::dp_cmd_t  cmd
);
  import tsor_pkg::*;

  ctrl_state_t       state_r, state_nxt;
  logic              phase_r, phase_nxt;   // 0: rhs pass, 1: sweep
  logic [1:0]        k_r, k_nxt;
  addr_t             j_r, j_nxt, n_r, n_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt, cnt1;
  logic [15:0]       step_r, step_nxt;
  logic [SWP_W-1:0]  sweep_r, sweep_nxt;
  logic              cap_r, cap_nxt;
  logic              oval_r, oval_nxt;
  addr_t             half;
  logic              step_last;

  assign half      = n_r >> 1;
  assign cnt1      = (count_r < CNT_W'(NODE_SLOTS + 1)) ? count_r + 1'b1 : count_r;
  assign step_last = ({1'b0, step_r} + 17'd1) == {1'b0, stat.time_steps};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 1'b0;
      k_r     <= '0;
      j_r     <= '0;
      n_r     <= '0;
      count_r <= '0;
      step_r  <= '0;
      sweep_r <= '0;
      cap_r   <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      n_r     <= n_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      sweep_r <= sweep_nxt;
      cap_r   <= cap_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    count_nxt = count_r;
    step_nxt  = step_r;
    sweep_nxt = sweep_r;
    cap_nxt   = cap_r;
    oval_nxt  = oval_r && out_stall;

    cmd         = '0;
    cmd.op      = OP_NOP;
    cmd.msel    = M_LL;
    cmd.g_raddr = j_r + 1'b1;
    cmd.r_raddr = j_r;
    cmd.g_waddr = j_r;
    cmd.r_waddr = j_r;
    cmd.weight  = j_r + 1'b1;
    cmd.status  = cap_r ? STATUS_CAP : STATUS_OK;

    unique case (state_r)
      // load one node a cycle
      ST_IDLE: begin
        if (in_valid) begin
          cmd.g_we    = count_r < CNT_W'(NODE_SLOTS);
          cmd.g_waddr = count_r[ADDR_W-1:0];
          cmd.g_wsel  = 1'b0;
          if (in_last_node) begin
            count_nxt = '0;
            if (cnt1 < CNT_W'(3) || cnt1 > CNT_W'(NODE_SLOTS) || !cnt1[0]) begin
              state_nxt = ST_BAD;
            end else begin
              n_nxt    = ADDR_W'(cnt1 - 1'b1);
              step_nxt = '0;
              cap_nxt  = 1'b0;
              phase_nxt = 1'b0;
              state_nxt = (stat.time_steps == 16'd0) ? ST_RES0 : ST_W0;
            end
          end else begin
            count_nxt = cnt1;
          end
        end
      end
      // prime the node window with nodes 0 and 1
      ST_W0: begin
        cmd.g_raddr = '0;
        j_nxt       = ADDR_W'(1);
        state_nxt   = ST_W1;
      end
      ST_W1: begin
        cmd.op      = OP_LEFT_Q;
        cmd.g_raddr = ADDR_W'(1);
        state_nxt   = ST_W2;
      end
      ST_W2: begin
        cmd.op    = OP_MID_Q;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        k_nxt     = '0;
        state_nxt = ST_LD;
      end
      ST_LD: begin
        cmd.op    = phase_r ? OP_RIGHT_RHS : OP_RIGHT_ZERO;
        state_nxt = ST_MSTART;
      end
      ST_MSTART: begin
        cmd.op = OP_MUL;
        if (!phase_r)
          cmd.msel = (k_r == 2'd0) ? M_RL : (k_r == 2'd1) ? M_RC : M_RR;
        else
          cmd.msel = (k_r == 2'd0) ? M_LL : (k_r == 2'd1) ? M_LR :
                     (k_r == 2'd2) ? M_OM : M_BOUND;
        state_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (stat.mul_done) begin
          if (!phase_r) begin
            cmd.op = OP_ACC_ADD;
            if (k_r == 2'd2) begin
              state_nxt = ST_RHS_WR;
            end else begin
              k_nxt     = k_r + 2'd1;
              state_nxt = ST_MSTART;
            end
          end else begin
            case (k_r)
              2'd0: begin cmd.op = OP_ACC_SUB; k_nxt = 2'd1; state_nxt = ST_MSTART; end
              2'd1: begin cmd.op = OP_ACC_SUB; state_nxt = ST_PRE_OM; end
              2'd2: begin cmd.op = OP_NEW; state_nxt = ST_TERM; end
              default: begin cmd.op = OP_BOUND; state_nxt = ST_CHECK; end
            endcase
          end
        end
      end
      ST_RHS_WR: begin
        cmd.r_we = 1'b1;
        cmd.op   = OP_SHIFT;
        j_nxt    = j_r + 1'b1;
        if (j_r + 1'b1 == n_r) begin
          sweep_nxt = '0;
          state_nxt = ST_SWP_START;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_PRE_OM: begin
        cmd.op    = OP_SUB_MID;
        k_nxt     = 2'd2;
        state_nxt = ST_MSTART;
      end
      ST_TERM: begin
        cmd.op    = OP_TERM;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op     = OP_SUM;
        cmd.g_we   = 1'b1;
        cmd.g_wsel = 1'b1;
        j_nxt      = j_r + 1'b1;
        if (j_r + 1'b1 == n_r) begin
          k_nxt     = 2'd3;
          state_nxt = ST_MSTART;
        end else begin
          state_nxt = ST_RD;
        end
      end
      // end of sweep: converged, capped or go again
      ST_CHECK: begin
        sweep_nxt = sweep_r + 1'b1;
        if (stat.converged || ({1'b0, sweep_r} + 1'b1) >= (SWP_W + 1)'(MAX_SWEEPS)) begin
          if (!stat.converged)
            cap_nxt = 1'b1;
          step_nxt  = step_r + 16'd1;
          phase_nxt = 1'b0;
          state_nxt = step_last ? ST_RES0 : ST_W0;
        end else begin
          state_nxt = ST_SWP_START;
        end
      end
      ST_SWP_START: begin
        cmd.op    = OP_CLR_SUMS;
        phase_nxt = 1'b1;
        state_nxt = ST_W0;
      end
      // read the middle node and its neighbours
      ST_RES0: begin
        cmd.g_raddr = half - 1'b1;
        state_nxt   = ST_RES1;
      end
      ST_RES1: begin
        cmd.op      = OP_LEFT_Q;
        cmd.g_raddr = half;
        state_nxt   = ST_RES2;
      end
      ST_RES2: begin
        cmd.op      = OP_MID_Q;
        cmd.g_raddr = half + 1'b1;
        state_nxt   = ST_RES3;
      end
      ST_RES3: begin
        cmd.op    = OP_RIGHT_ZERO;
        state_nxt = ST_RES4;
      end
      ST_RES4: begin
        if (!oval_r) begin
          cmd.op    = OP_RESULT;
          oval_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_BAD: begin
        if (!oval_r) begin
          cmd.op     = OP_RESULT;
          cmd.status = STATUS_BAD;
          oval_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = oval_r;

endmodule
